// ----- design/dmf_pkg.sv -----
// dmf_pkg: shared types and constants for the duplicate message filter
// holds verdict codes, controller states and the control/status structs
// no dependencies
package dmf_pkg;

	// field widths
	localparam int unsigned ADDR_W   = 16;
	localparam int unsigned EP_W     = 8;
	localparam int unsigned SEQ_W    = 8;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned WIN_W    = 8;
	localparam int unsigned VERD_W   = 2;
	localparam int unsigned RECORD_W = ADDR_W + EP_W + SEQ_W + TIME_W;

	// verdict codes
	localparam logic [VERD_W-1:0] VERDICT_NEW  = 2'd0;
	localparam logic [VERD_W-1:0] VERDICT_DUP  = 2'd1;
	localparam logic [VERD_W-1:0] VERDICT_FULL = 2'd2;

	// window register value after reset
	localparam logic [WIN_W-1:0] WINDOW_RESET = 8'd2;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} dmf_state_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic commit;
	} dmf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_done;
	} dmf_status_t;

endpackage

// ----- design/dmf_ctrl.sv -----
// dmf_ctrl: controller state machine of the duplicate message filter
// sequences accept, table scan and commit, and owns the output valid flag
// depends on dmf_pkg
module dmf_ctrl
	import dmf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	output logic        out_valid,
	input  logic        out_stall,
	output dmf_cmd_t    cmd,
	input  dmf_status_t status
);

	dmf_state_t state_q;
	dmf_state_t state_d;
	logic       out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd.start  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.commit = 1'b0;
		in_stall   = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (status.scan_done) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				// wait until the output register is free or being emptied
				if (!out_valid_q || !out_stall) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/dmf_datapath.sv -----
// dmf_datapath: record table, fill count, scan pipeline and verdict register
// one-read one-write record memory with registered read data
// depends on dmf_pkg
module dmf_datapath
	import dmf_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dmf_cmd_t            cmd,
	output dmf_status_t         status,
	input  logic                cfg_write,
	input  logic [WIN_W-1:0]    cfg_data,
	input  logic [ADDR_W-1:0]   source_address,
	input  logic [EP_W-1:0]     source_endpoint,
	input  logic [SEQ_W-1:0]    sequence_number,
	input  logic [TIME_W-1:0]   now_seconds,
	output logic [VERD_W-1:0]   verdict
);

	localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

	// record memory, no reset: entries at and beyond the fill count are never read
	logic [RECORD_W-1:0] mem_q [TABLE_DEPTH];

	logic [WIN_W-1:0]    window_q;
	logic [ADDR_W-1:0]   addr_q;
	logic [EP_W-1:0]     ep_q;
	logic [SEQ_W-1:0]    seq_q;
	logic [TIME_W-1:0]   now_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic                rd_vld_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [RECORD_W-1:0] rd_data_s1;
	logic                hit_q;
	logic                dup_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic                exp_q;
	logic [IDX_W-1:0]    exp_idx_q;
	logic [VERD_W-1:0]   verdict_q;

	logic                issue;
	logic [ADDR_W-1:0]   rec_addr;
	logic [EP_W-1:0]     rec_ep;
	logic [SEQ_W-1:0]    rec_seq;
	logic [TIME_W-1:0]   rec_time;
	logic [TIME_W:0]     win_end;
	logic                now_ge_end;
	logic                hit_now;
	logic                exp_now;
	logic                has_room;
	logic [VERD_W-1:0]   verdict_d;
	logic [IDX_W-1:0]    wr_idx;
	logic                wr_en;

	// window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_write) begin
			window_q <= cfg_data;
		end
	end

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q <= source_address;
			ep_q   <= source_endpoint;
			seq_q  <= sequence_number;
			now_q  <= now_seconds;
		end
	end

	// unpack the record under compare
	assign rec_addr = rd_data_s1[RECORD_W-1 -: ADDR_W];
	assign rec_ep   = rd_data_s1[TIME_W+SEQ_W+EP_W-1 -: EP_W];
	assign rec_seq  = rd_data_s1[TIME_W+SEQ_W-1 -: SEQ_W];
	assign rec_time = rd_data_s1[TIME_W-1:0];

	// window end is one bit wider so it never wraps
	assign win_end    = {1'b0, rec_time} + {{(TIME_W+1-WIN_W){1'b0}}, window_q};
	assign now_ge_end = {1'b0, now_q} >= win_end;

	assign hit_now = rd_vld_s1 && !hit_q && (rec_addr == addr_q) &&
		(rec_ep == ep_q) && (rec_seq == seq_q);
	assign exp_now = rd_vld_s1 && !exp_q && now_ge_end;

	// read issue: walk the valid prefix until a match shows up
	assign issue = cmd.scan && !hit_q && !hit_now && (rd_idx_q < count_q);

	assign status.scan_done = hit_q || (!rd_vld_s1 && (rd_idx_q >= count_q));

	// scan pointer and read pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			exp_q     <= 1'b0;
		end else if (cmd.start) begin
			rd_idx_q  <= '0;
			rd_vld_s1 <= 1'b0;
			hit_q     <= 1'b0;
			exp_q     <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (hit_now) begin
				hit_q <= 1'b1;
			end
			if (exp_now) begin
				exp_q <= 1'b1;
			end
		end
	end

	// first match and first expired record
	always_ff @(posedge clk) begin
		rd_idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (hit_now) begin
			hit_idx_q <= rd_idx_s1;
			dup_q     <= !now_ge_end;
		end
		if (exp_now) begin
			exp_idx_q <= rd_idx_s1;
		end
	end

	// verdict and write target
	assign has_room = count_q < DEPTH_C;

	always_comb begin
		if (hit_q) begin
			verdict_d = dup_q ? VERDICT_DUP : VERDICT_NEW;
			wr_idx    = hit_idx_q;
		end else if (exp_q) begin
			verdict_d = VERDICT_NEW;
			wr_idx    = exp_idx_q;
		end else begin
			verdict_d = has_room ? VERDICT_NEW : VERDICT_FULL;
			wr_idx    = count_q[IDX_W-1:0];
		end
	end

	assign wr_en = cmd.commit && (verdict_d != VERDICT_FULL);

	// record memory ports
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_data_s1 <= mem_q[rd_idx_q[IDX_W-1:0]];
		end
		if (wr_en) begin
			mem_q[wr_idx] <= {addr_q, ep_q, seq_q, now_q};
		end
	end

	// fill count: valid records always form a prefix of the table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit && !hit_q && !exp_q && has_room) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			verdict_q <= verdict_d;
		end
	end

	assign verdict = verdict_q;

endmodule

// ----- design/duplicate_message_filter_core.sv -----
// an accepted item is captured, scanned against the filled part of the table and then
// committed to the output register; an output stall can hold the commit
// one item at a time, the next taken after commit; the scan reads one record per cycle
// from the single read port of the record memory and stops at the first match
// a new item is taken while an earlier result still waits in the output register
// reset: asynchronous, clears fill count and control state, window returns to 2
module duplicate_message_filter_core
	import dmf_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [WIN_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [ADDR_W-1:0] source_address,
	input  logic [EP_W-1:0]   source_endpoint,
	input  logic [SEQ_W-1:0]  sequence_number,
	input  logic [TIME_W-1:0] now_seconds,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [VERD_W-1:0] verdict
);

	dmf_cmd_t    cmd;
	dmf_status_t status;

	// controller
	dmf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	// datapath
	dmf_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_write       (cfg_write),
		.cfg_data        (cfg_data),
		.source_address  (source_address),
		.source_endpoint (source_endpoint),
		.sequence_number (sequence_number),
		.now_seconds     (now_seconds),
		.verdict         (verdict)
	);

`ifndef ASSERT_OFF
	// an item never turns into a result in the cycle right after it is taken
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !$rose(out_valid))
		else $error("result appeared right after accept");

	// a fresh result is only produced while the input side was busy
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result produced while idle");

	// only defined verdict codes leave the block
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (verdict == VERDICT_NEW || verdict == VERDICT_DUP ||
			verdict == VERDICT_FULL))
		else $error("undefined verdict code");
`endif

endmodule

// ----- test/dmf_checker.sv -----
`timescale 1ns / 1ps
// dmf_checker: watches both channels of the duplicate message filter, keeps its own
// copy of the record table and window, and compares every verdict with the prediction
// depends on dmf_pkg for field widths, verdict codes and the window reset value
module dmf_checker
	import dmf_pkg::*;
#(
	parameter int unsigned TABLE_DEPTH = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [WIN_W-1:0]  cfg_data,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [ADDR_W-1:0] source_address,
	input  logic [EP_W-1:0]   source_endpoint,
	input  logic [SEQ_W-1:0]  sequence_number,
	input  logic [TIME_W-1:0] now_seconds,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic [VERD_W-1:0] verdict,
	output int                mismatches,
	output int                pending,
	output int                new_seen,
	output int                dup_seen,
	output int                full_seen
);

	// shadow copy of the window register and the record table
	logic [WIN_W-1:0]  window;
	logic              rec_used [TABLE_DEPTH];
	logic [ADDR_W-1:0] rec_addr [TABLE_DEPTH];
	logic [EP_W-1:0]   rec_ep   [TABLE_DEPTH];
	logic [SEQ_W-1:0]  rec_seq  [TABLE_DEPTH];
	logic [TIME_W-1:0] rec_time [TABLE_DEPTH];

	// verdicts still owed by the block, oldest first
	logic [VERD_W-1:0] expected_verdicts [$];

	initial begin
		mismatches = 0;
		pending    = 0;
		new_seen   = 0;
		dup_seen   = 0;
		full_seen  = 0;
	end

	// end of the duplicate window of a record, one bit wider so it never wraps
	function automatic logic [TIME_W:0] expiry_of(int idx);
		logic [TIME_W:0] sum;
		sum = {1'b0, rec_time[idx]} + {{(TIME_W+1-WIN_W){1'b0}}, window};
		return sum;
	endfunction

	// look the message up, update the table and work out its verdict
	task automatic judge_message(
		input  logic [ADDR_W-1:0] addr,
		input  logic [EP_W-1:0]   ep,
		input  logic [SEQ_W-1:0]  seq,
		input  logic [TIME_W-1:0] now,
		output logic [VERD_W-1:0] result
	);
		int hit;
		int slot;
		logic [TIME_W:0] now_wide;
		hit = -1;
		slot = -1;
		now_wide = {1'b0, now};
		result = VERDICT_NEW;
		// first valid record with all three keys equal
		for (int i = 0; i < TABLE_DEPTH && hit < 0; i++) begin
			if (rec_used[i] && rec_addr[i] == addr && rec_ep[i] == ep && rec_seq[i] == seq)
				hit = i;
		end
		if (hit >= 0) begin
			if (now_wide < expiry_of(hit))
				result = VERDICT_DUP;
			rec_time[hit] = now;
		end else begin
			// first record that is free or whose window has passed
			for (int i = 0; i < TABLE_DEPTH && slot < 0; i++) begin
				if (!rec_used[i] || now_wide >= expiry_of(i))
					slot = i;
			end
			if (slot >= 0) begin
				rec_used[slot] = 1'b1;
				rec_addr[slot] = addr;
				rec_ep[slot]   = ep;
				rec_seq[slot]  = seq;
				rec_time[slot] = now;
			end else begin
				result = VERDICT_FULL;
			end
		end
	endtask

	// sample both channels and the register port at each rising edge
	always @(posedge clk) begin : watch
		logic [VERD_W-1:0] want;
		logic [VERD_W-1:0] predicted;
		if (!arst_n) begin
			window = WINDOW_RESET;
			foreach (rec_used[i])
				rec_used[i] = 1'b0;
			expected_verdicts.delete();
		end else begin
			// results first: a result never belongs to the item taken at the same edge
			if (out_valid && !out_stall) begin
				if (expected_verdicts.size() == 0) begin
					$error("verdict: no item waiting, expected none, actual %0d", verdict);
					mismatches++;
				end else begin
					want = expected_verdicts.pop_front();
					if (verdict !== want) begin
						$error("verdict: expected %0d, actual %0d", want, verdict);
						mismatches++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				judge_message(source_address, source_endpoint, sequence_number, now_seconds,
					predicted);
				expected_verdicts.push_back(predicted);
				case (predicted)
					VERDICT_NEW: new_seen++;
					VERDICT_DUP: dup_seen++;
					default:     full_seen++;
				endcase
			end
			if (cfg_write)
				window = cfg_data;
		end
		pending = expected_verdicts.size();
	end

endmodule

// ----- test/duplicate_message_filter_core_tb.sv -----
`timescale 1ns / 1ps
// duplicate_message_filter_core_tb: drives messages and window settings into the filter
// and gives the verdict; prediction and comparison live in dmf_checker
// depends on dmf_pkg, duplicate_message_filter_core and dmf_checker
module duplicate_message_filter_core_tb;
	import dmf_pkg::*;

	localparam int unsigned TABLE_DEPTH    = 256;
	localparam int          WATCHDOG_LIMIT = 4000;
	localparam int          HOLD_CYCLES    = 400;
	localparam int          DRAIN_CYCLES   = TABLE_DEPTH + 8;
	localparam int          POOL_SIZE      = 8;
	localparam int          FLOOD_KEYS     = TABLE_DEPTH + 8;

	// the three lookup keys of one message
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [EP_W-1:0]   ep;
		logic [SEQ_W-1:0]  seq;
	} msg_key_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_write;
	logic [WIN_W-1:0]  cfg_data;
	logic              in_valid;
	logic              in_stall;
	logic [ADDR_W-1:0] source_address;
	logic [EP_W-1:0]   source_endpoint;
	logic [SEQ_W-1:0]  sequence_number;
	logic [TIME_W-1:0] now_seconds;
	logic              out_valid;
	logic              out_stall;
	logic [VERD_W-1:0] verdict;

	int mismatches;
	int pending;
	int new_seen;
	int dup_seen;
	int full_seen;

	// flags and counters for the stimulus, receiver and watchdog processes
	bit         calm;
	bit         hold_wanted;
	int         idle_pct;
	int         settings_used;
	logic [WIN_W-1:0] window_now;
	int         quiet_cycles = 0;

	duplicate_message_filter_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.source_address (source_address),
		.source_endpoint(source_endpoint),
		.sequence_number(sequence_number),
		.now_seconds    (now_seconds),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.verdict        (verdict)
	);

	dmf_checker #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.source_address (source_address),
		.source_endpoint(source_endpoint),
		.sequence_number(sequence_number),
		.now_seconds    (now_seconds),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.verdict        (verdict),
		.mismatches     (mismatches),
		.pending        (pending),
		.new_seen       (new_seen),
		.dup_seen       (dup_seen),
		.full_seen      (full_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog: too long without any item moving on either channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else begin
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("watchdog: nothing moved for %0d cycles", quiet_cycles);
					$display("status: fail");
					$finish;
				end
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// receiver: random stall bursts, plus one long hold-off on request
	initial begin : receiver
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_wanted) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_stall <= 1'b0;
				hold_wanted = 1'b0;
			end else if (!calm && $urandom_range(1, 100) <= idle_pct) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 16)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// offer one item at the current falling edge and hold it until taken
	task automatic offer_message(input msg_key_t k, input logic [TIME_W-1:0] t);
		source_address  <= k.addr;
		source_endpoint <= k.ep;
		sequence_number <= k.seq;
		now_seconds     <= t;
		in_valid        <= 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		// sender gap
		if (!calm && $urandom_range(1, 100) <= idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(negedge clk);
		end
	endtask

	// wait for the block to drain, then write the window register
	task automatic set_window(input logic [WIN_W-1:0] w);
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		cfg_data   <= w;
		cfg_write  <= 1'b1;
		window_now = w;
		settings_used++;
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// random traffic around a small pool of senders, with noise and near misses
	task automatic run_phase(input logic [WIN_W-1:0] w, input int count, input int pct,
		input logic [TIME_W-1:0] start_time);
		msg_key_t pool [POOL_SIZE];
		msg_key_t k;
		logic [TIME_W-1:0] t;
		int pick;
		set_window(w);
		idle_pct = pct;
		foreach (pool[i])
			pool[i] = {16'($urandom), 8'($urandom), 8'($urandom)};
		t = start_time;
		for (int n = 0; n < count; n++) begin
			// time mostly stays put, often steps forward, sometimes past the window, rarely back
			pick = $urandom_range(0, 19);
			if (pick >= 11 && pick <= 15)
				t = t + $urandom_range(1, 3);
			else if (pick >= 16 && pick <= 18)
				t = t + $urandom_range(0, 2 * int'(window_now) + 2);
			else if (pick == 19)
				t = t - $urandom_range(1, 300);
			// mostly known senders, some fresh ones, some differing in one key
			pick = $urandom_range(0, 15);
			k = pool[$urandom_range(0, POOL_SIZE - 1)];
			if (pick < 3) begin
				k = {16'($urandom), 8'($urandom), 8'($urandom)};
			end else if (pick == 3) begin
				case ($urandom_range(0, 2))
					0: k.addr = k.addr ^ (16'd1 << $urandom_range(0, ADDR_W - 1));
					1: k.ep = k.ep ^ (8'd1 << $urandom_range(0, EP_W - 1));
					default: k.seq = k.seq ^ (8'd1 << $urandom_range(0, SEQ_W - 1));
				endcase
			end
			offer_message(k, t);
		end
	endtask

	// stimulus
	initial begin : stimulus
		msg_key_t key_a;
		msg_key_t key_b;
		msg_key_t key_c;
		msg_key_t key_d;
		msg_key_t key_e;
		msg_key_t flood_keys [FLOOD_KEYS];
		logic [TIME_W-1:0] flood_t0;
		logic [ADDR_W-1:0] flood_base;
		arst_n          = 1'b0;
		cfg_write       = 1'b0;
		cfg_data        = '0;
		in_valid        = 1'b0;
		source_address  = '0;
		source_endpoint = '0;
		sequence_number = '0;
		now_seconds     = '0;
		calm            = 1'b0;
		hold_wanted     = 1'b0;
		idle_pct        = 10;
		settings_used   = 1;
		window_now      = WINDOW_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// window from reset: repeat, stale repeat, extreme keys, time going back
		key_a = {16'h1234, 8'h01, 8'h07};
		key_b = {16'hffff, 8'hff, 8'hff};
		key_c = {16'h0000, 8'h00, 8'h00};
		key_d = {16'h8000, 8'h80, 8'h80};
		key_e = {16'h00ff, 8'h0f, 8'hf0};
		offer_message(key_a, 32'd100);
		offer_message(key_a, 32'd101);
		offer_message(key_a, 32'd103);
		offer_message(key_b, 32'd103);
		offer_message(key_c, 32'd103);
		offer_message(key_b, 32'd104);
		offer_message(key_a, 32'd50);
		offer_message(key_d, 32'd10);

		// zero window: a record expires at its own time, only a later record gives a duplicate
		set_window(8'd0);
		offer_message(key_a, 32'd50);
		offer_message(key_a, 32'd50);
		offer_message(key_c, 32'd0);

		// widest window near the top of the time range, sum must not wrap
		set_window(8'd255);
		offer_message(key_e, 32'hffff_fff0);
		offer_message(key_e, 32'hffff_ffff);
		offer_message(key_e, 32'h0000_0000);
		offer_message(key_e, 32'hffff_ffff);

		// random phases over several windows
		run_phase(8'd1, 50, 30, $urandom);
		run_phase(8'd0, 50, 0, $urandom);
		run_phase(8'd255, 50, 10, $urandom);
		run_phase(8'($urandom_range(3, 254)), 50, 30, $urandom);
		run_phase(WINDOW_RESET, 50, 10, $urandom);

		// fill the table until it reports full, under a long output hold-off
		set_window(8'd255);
		idle_pct = 10;
		hold_wanted = 1'b1;
		flood_t0 = $urandom_range(0, 32'h7fff_ffff);
		flood_base = 16'($urandom);
		for (int n = 0; n < FLOOD_KEYS; n++) begin
			flood_keys[n].addr = flood_base + ADDR_W'(n);
			flood_keys[n].ep   = 8'($urandom);
			flood_keys[n].seq  = 8'($urandom);
			offer_message(flood_keys[n], flood_t0);
			if (n % 40 == 39)
				offer_message(flood_keys[$urandom_range(0, n)], flood_t0);
		end
		for (int n = 0; n < 4; n++)
			offer_message(flood_keys[$urandom_range(0, FLOOD_KEYS - 1)], flood_t0);
		// once the window has passed, records are free again
		offer_message(key_d, flood_t0 + 256);
		offer_message(key_d, flood_t0 + 257);

		// last part without any idling
		calm = 1'b1;
		run_phase(WINDOW_RESET, 30, 0, flood_t0 + 1000);

		// drain and give the verdict
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d messages over %0d window settings", new_seen + dup_seen + full_seen,
			settings_used);
		$display("verdicts seen: %0d new, %0d duplicate, %0d table full", new_seen, dup_seen,
			full_seen);
		if (mismatches == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
design/dmf_pkg.sv
design/dmf_ctrl.sv
design/dmf_datapath.sv
design/duplicate_message_filter_core.sv
test/dmf_checker.sv
test/duplicate_message_filter_core_tb.sv
